>>> rtl/itaf_pkg.sv
// shared types, constants and the digit table of the integer to ascii formatter
package itaf_pkg;

   // format kinds carried by req_type
   localparam logic [1:0] KIND_SIGNED   = 2'd0;
   localparam logic [1:0] KIND_UNSIGNED = 2'd1;
   localparam logic [1:0] KIND_HEX      = 2'd2;

   // ascii codes of the fixed characters
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;

   // value and digit stack sizes
   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned DIGIT_DEPTH = 10;
   localparam int unsigned COUNT_W     = 4;

   // reciprocal of ten: floor(n * RECIP_TEN / 2^35) == n / 10 for any 32-bit n
   localparam logic [31:0] RECIP_TEN  = 32'hcccc_cccd;
   localparam int unsigned RECIP_SHIFT = 35;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic mul;
      logic step;
      logic emit_pre;
      logic emit_dig;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic q_zero;
      logic has_prefix;
      logic pre_last;
      logic cnt_last;
      logic out_free;
   } sts_type;

   // lowercase hex digit to ascii
   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      case (d) inside
         [4'd0:4'd9]: c = CHAR_ZERO + {4'd0, d};
         default:     c = 8'h57 + {4'd0, d};
      endcase
      return c;
   endfunction

endpackage

>>> rtl/integer_to_ascii_formatter.sv
// top level of the integer to ascii formatter
//
// The req channel takes one transaction: a 32-bit req_value and a format kind
// req_type (0 signed decimal, 1 unsigned decimal, 2 or 3 hexadecimal with "0x").
// The rsp channel returns the text one ascii character per transaction, most
// significant first, no leading zeros; rsp_last_char marks the final one.
// Both channels use valid/ready.
//
// One number is handled at a time: req_ready returns only after the last
// character of the number has entered the output register, so a new number is
// not accepted while one is still being converted. Each digit passes through
// the multiply state (the reciprocal product, used for decimal) and then the
// remainder and stack push state. The first character leaves only after every
// digit of the number is on the stack.
// A stalled receiver holds the output register and pauses character emission;
// the last character may still wait while the next number is accepted.
// Synchronous reset returns the controller to idle and drops rsp_valid.
module integer_to_ascii_formatter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last_char
);
   import itaf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // controller
   itaf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   itaf_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_type      (req_type),
      .req_value     (req_value),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   // at most one command at a time
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mul, cmd.step, cmd.emit_pre, cmd.emit_dig}))
      else $error("more than one datapath command");

   // an accepted transaction starts conversion, no second accept next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready right after accept");

   // the last character returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_dig && sts.cnt_last) |=> (req_ready && rsp_valid && rsp_last_char))
      else $error("last character did not end the number");

endmodule

>>> rtl/itaf_ctrl.sv
// controller state machine of the integer to ascii formatter
module itaf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  itaf_pkg::sts_type sts,
   output itaf_pkg::cmd_type cmd
);
   import itaf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_REM  = 5'b00100,
      ST_PRE  = 5'b01000,
      ST_DIG  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.mul  = 1'b1;
            state_in = ST_REM;
         end
         ST_REM: begin
            cmd.step = 1'b1;
            if (sts.q_zero) begin
               state_in = sts.has_prefix ? ST_PRE : ST_DIG;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_PRE: begin
            if (sts.out_free) begin
               cmd.emit_pre = 1'b1;
               if (sts.pre_last) state_in = ST_DIG;
            end
         end
         ST_DIG: begin
            if (sts.out_free) begin
               cmd.emit_dig = 1'b1;
               if (sts.cnt_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/itaf_dp.sv
// datapath of the integer to ascii formatter: magnitude, divider, digit stack, output register
module itaf_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    req_type,
   input  logic [itaf_pkg::VALUE_W-1:0]  req_value,
   input  itaf_pkg::cmd_type             cmd,
   output itaf_pkg::sts_type             sts,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_out_char,
   output logic                          rsp_last_char
);
   import itaf_pkg::*;

   logic [VALUE_W-1:0]   mag_ff;
   logic [2*VALUE_W-1:0] prod_ff;
   logic [3:0]           stack_ff [DIGIT_DEPTH];
   logic [COUNT_W-1:0]   cnt_ff;
   logic                 hex_ff;
   logic                 neg_ff;
   logic                 pre_idx_ff;
   logic                 valid_ff;
   logic [7:0]           char_ff;
   logic                 last_ff;

   logic                 neg_in;
   logic [VALUE_W-1:0]   quot;
   logic [VALUE_W-1:0]   times_ten;
   logic [VALUE_W-1:0]   rem_full;
   logic [3:0]           digit;
   logic [7:0]           pre_char;

   assign neg_in = (req_type == KIND_SIGNED) && req_value[VALUE_W-1];

   // quotient and remainder of one division step
   always_comb begin
      if (hex_ff) begin
         quot = {4'd0, mag_ff[VALUE_W-1:4]};
      end else begin
         quot = {{RECIP_SHIFT-VALUE_W{1'b0}}, prod_ff[2*VALUE_W-1:RECIP_SHIFT]};
      end
      times_ten = {quot[VALUE_W-4:0], 3'b000} + {quot[VALUE_W-2:0], 1'b0};
      rem_full  = mag_ff - times_ten;
      if (hex_ff) begin
         digit = mag_ff[3:0];
      end else begin
         digit = rem_full[3:0];
      end
   end

   // prefix character
   always_comb begin
      if (hex_ff) begin
         pre_char = pre_idx_ff ? CHAR_X : CHAR_ZERO;
      end else begin
         pre_char = CHAR_MINUS;
      end
   end

   // status to the controller
   always_comb begin
      sts.q_zero     = (quot == '0);
      sts.has_prefix = hex_ff | neg_ff;
      sts.pre_last   = ~hex_ff | pre_idx_ff;
      sts.cnt_last   = (cnt_ff == COUNT_W'(1));
      sts.out_free   = ~valid_ff | rsp_ready;
   end

   // magnitude, product and digit stack
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff     <= neg_in ? (VALUE_W'(0) - req_value) : req_value;
         hex_ff     <= req_type[1];
         neg_ff     <= neg_in;
         cnt_ff     <= '0;
         pre_idx_ff <= 1'b0;
      end
      if (cmd.mul) begin
         prod_ff <= mag_ff * RECIP_TEN;
      end
      if (cmd.step) begin
         mag_ff <= quot;
         cnt_ff <= cnt_ff + COUNT_W'(1);
         stack_ff[0] <= digit;
         for (int i = 1; i < DIGIT_DEPTH; i++) stack_ff[i] <= stack_ff[i-1];
      end
      if (cmd.emit_pre) begin
         pre_idx_ff <= 1'b1;
      end
      if (cmd.emit_dig) begin
         cnt_ff <= cnt_ff - COUNT_W'(1);
         for (int i = 0; i < DIGIT_DEPTH - 1; i++) stack_ff[i] <= stack_ff[i+1];
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (cmd.emit_pre) begin
         char_ff <= pre_char;
         last_ff <= 1'b0;
      end else if (cmd.emit_dig) begin
         char_ff <= digit_char(stack_ff[0]);
         last_ff <= sts.cnt_last;
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit_pre | cmd.emit_dig) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = last_ff;

endmodule
